[src/imudr_pkg.sv]
// imudr_pkg: shared types, constants and small functions for the imu dead reckoning block
package imudr_pkg;

    typedef struct packed {
        logic signed [23:0] accel_x;
        logic signed [23:0] accel_y;
        logic signed [23:0] yaw_rate;
        logic        [47:0] stamp_us;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
        logic        [47:0] stamp_out;
    } t_out;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DT,
        ST_MUL,
        ST_DLD,
        ST_DEST,
        ST_DBACK,
        ST_DSUB,
        ST_DFIX,
        ST_DACC,
        ST_SUM,
        ST_SQRT,
        ST_CINIT,
        ST_CORDIC,
        ST_CDONE,
        ST_POS,
        ST_MAG,
        ST_HEAD,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_AX,
        OP_AY,
        OP_VX2,
        OP_VY2,
        OP_SPDC,
        OP_SPDS,
        OP_PX,
        OP_PY,
        OP_RATE,
        OP_HI,
        OP_LO
    } t_op;

    localparam logic [1:0] CFG_INIT_X       = 2'd0;
    localparam logic [1:0] CFG_INIT_Y       = 2'd1;
    localparam logic [1:0] CFG_INIT_HEADING = 2'd2;

    localparam int                 CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [33:0] RAD_US_K     = 34'sd716770142;
    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
    localparam logic        [20:0] US_PER_S     = 21'd1000000;
    // floor of 2^52 / 1e6
    localparam logic signed [33:0] RECIP_US     = 34'sd4503599627;

    function automatic logic signed [33:0] atan_at(input logic [4:0] idx);
        logic signed [33:0] v;
        case (idx)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            5'd24:   v = 34'sd41;
            5'd25:   v = 34'sd20;
            5'd26:   v = 34'sd10;
            5'd27:   v = 34'sd5;
            5'd28:   v = 34'sd3;
            5'd29:   v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30) begin
            r = 32'sd1073741824;
        end else if (v < -ONE_Q30) begin
            r = -32'sd1073741824;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[src/imu_dead_reckoning.sv]
// imu_dead_reckoning: planar dead reckoning top level with a shared-unit sequencer
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one imu sample per
// transfer; output channel (o_out_valid / i_out_stall / o_out_data) gives one
// pose result per sample. The configuration channel (i_cfg_valid / o_cfg_ready)
// writes the initial pose registers; it is always ready.
// The first sample after reset loads the initial pose. Each later sample runs
// through one shared 34x34 multiplier (products and reciprocal estimates for
// the four divisions by 1e6), a 32 step square root and a 30 step cordic (used
// twice); the square root and the two cordic runs take most of the time for a
// sample. A new sample can be taken once the result is loaded into the output
// register, so a sample is never taken while the last one is still in work.
// o_in_stall is high from the transfer until the result is loaded into the
// output register.
// The output register holds a finished result while the next sample is taken;
// if it is still full when the next result is ready, the sequencer waits.
// Reset (synchronous, active low) clears the pose state, the configuration
// registers and the output valid; the next sample is treated as the first.
module imu_dead_reckoning #(
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  imudr_pkg::t_in       i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output imudr_pkg::t_out      o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import imudr_pkg::*;

    localparam int HEAD_SH = FRAC_BITS + 28 - ANGLE_BITS;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_half, n_half;
    logic [5:0] r_cnt, n_cnt;

    t_in  r_in, n_in;
    logic r_seen, n_seen;
    logic [47:0] r_prev, n_prev;
    logic signed [31:0] r_vx, n_vx, r_vy, n_vy, r_ex, n_ex, r_ey, n_ey;
    logic [ANGLE_BITS-1:0] r_heading, n_heading;
    logic [31:0] r_cfg_x, n_cfg_x, r_cfg_y, n_cfg_y, r_cfg_h, n_cfg_h;

    logic signed [31:0] r_dt, n_dt;
    logic signed [67:0] r_prod, n_prod;
    logic [63:0] r_sq, n_sq, r_num, n_num;
    logic [44:0] r_quo, n_quo;
    logic [43:0] r_qest, n_qest;
    logic [63:0] r_back, n_back;
    logic        r_neg, n_neg;
    logic [33:0] r_srem, n_srem;
    logic [31:0] r_root, n_root;
    logic signed [33:0] r_cx, n_cx, r_cy, n_cy, r_cz, n_cz, r_p, n_p;
    logic [1:0]  r_q, n_q;
    logic signed [31:0] r_cos, n_cos, r_sin, n_sin;
    logic [54:0] r_mag, n_mag;
    t_out r_out, n_out;
    logic r_out_valid, n_out_valid;

    // shared datapath pieces
    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod;
    logic signed [48:0] w_diff;
    logic [63:0] w_back;
    logic signed [45:0] w_q;
    logic signed [31:0] w_base;
    logic signed [46:0] w_acc;
    logic [33:0] w_srsh, w_trial;
    logic signed [33:0] w_dx, w_dy, w_atan, w_mc, w_ms;
    logic [31:0] w_h32, w_ang;
    logic signed [67:0] w_pos;
    logic [63:0] w_inc;

    assign w_prod = w_ma * w_mb;
    assign w_diff = $signed({1'b0, r_in.stamp_us}) - $signed({1'b0, r_prev});
    // quotient estimate times one million as shifts and adds
    assign w_back = ({20'd0, r_qest} << 20) - ({20'd0, r_qest} << 16)
                  + ({20'd0, r_qest} << 14) + ({20'd0, r_qest} << 9)
                  + ({20'd0, r_qest} << 6);
    assign w_q    = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_acc  = 47'(w_base) + 47'(w_q);
    assign w_srsh = {r_srem[31:0], r_num[63:62]};
    assign w_trial = {r_root, 2'b01};
    assign w_dx   = r_cy >>> r_cnt[4:0];
    assign w_dy   = r_cx >>> r_cnt[4:0];
    assign w_atan = atan_at(r_cnt[4:0]);
    assign w_h32  = 32'(r_heading) << (32 - ANGLE_BITS);
    assign w_ang  = r_half ? (w_h32 >> 1) : w_h32;
    assign w_pos  = r_prod[67] ? ((r_prod + 68'sd1073741823) >>> 30) : (r_prod >>> 30);
    assign w_inc  = (r_sq + (r_prod[63:0] >> 24)) >> HEAD_SH;

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == ST_DEST) begin
            // reciprocal estimate: coarse on the top bits, then fine on the small remainder
            w_ma = r_cnt[0] ? $signed({1'b0, r_num[32:0]}) : $signed({2'b0, r_num[62:31]});
            w_mb = RECIP_US;
        end else begin
            unique case (r_op)
                OP_AX:   begin w_ma = 34'(r_in.accel_x);  w_mb = 34'(r_dt);   end
                OP_AY:   begin w_ma = 34'(r_in.accel_y);  w_mb = 34'(r_dt);   end
                OP_VX2:  begin w_ma = 34'(r_vx);          w_mb = 34'(r_vx);   end
                OP_VY2:  begin w_ma = 34'(r_vy);          w_mb = 34'(r_vy);   end
                OP_SPDC: begin w_ma = $signed({2'b0, r_root}); w_mb = 34'(r_cos); end
                OP_SPDS: begin w_ma = $signed({2'b0, r_root}); w_mb = 34'(r_sin); end
                OP_PX,
                OP_PY:   begin w_ma = r_p;                w_mb = 34'(r_dt);   end
                OP_RATE: begin w_ma = 34'(r_in.yaw_rate); w_mb = 34'(r_dt);   end
                OP_HI:   begin w_ma = $signed({3'b0, r_mag[54:24]}); w_mb = RAD_US_K; end
                OP_LO:   begin w_ma = $signed({10'b0, r_mag[23:0]}); w_mb = RAD_US_K; end
                default: begin w_ma = '0; w_mb = '0; end
            endcase
        end
    end

    // accumulator base for the divider result
    always_comb begin
        case (r_op)
            OP_AX:   w_base = r_vx;
            OP_AY:   w_base = r_vy;
            OP_PX:   w_base = r_ex;
            default: w_base = r_ey;
        endcase
    end

    // cordic quadrant fold
    always_comb begin
        unique case (r_q)
            2'd0:    begin w_mc = r_cx;  w_ms = r_cy;  end
            2'd1:    begin w_mc = -r_cy; w_ms = r_cx;  end
            2'd2:    begin w_mc = -r_cx; w_ms = -r_cy; end
            default: begin w_mc = r_cy;  w_ms = -r_cx; end
        endcase
    end

    always_comb begin
        n_state = r_state;   n_op = r_op;       n_half = r_half;   n_cnt = r_cnt;
        n_in = r_in;         n_seen = r_seen;   n_prev = r_prev;
        n_vx = r_vx;         n_vy = r_vy;       n_ex = r_ex;       n_ey = r_ey;
        n_heading = r_heading;
        n_cfg_x = r_cfg_x;   n_cfg_y = r_cfg_y; n_cfg_h = r_cfg_h;
        n_dt = r_dt;         n_prod = r_prod;   n_sq = r_sq;       n_num = r_num;
        n_quo = r_quo;       n_qest = r_qest;   n_back = r_back;
        n_neg = r_neg;       n_srem = r_srem;   n_root = r_root;
        n_cx = r_cx;         n_cy = r_cy;       n_cz = r_cz;       n_p = r_p;
        n_q = r_q;           n_cos = r_cos;     n_sin = r_sin;     n_mag = r_mag;
        n_out = r_out;
        n_out_valid = r_out_valid & i_out_stall;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INIT_X:       n_cfg_x = i_cfg_data;
                CFG_INIT_Y:       n_cfg_y = i_cfg_data;
                CFG_INIT_HEADING: n_cfg_h = i_cfg_data;
                default:          ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_in   = i_in_data;
                    if (!r_seen) begin
                        n_seen    = 1'b1;
                        n_prev    = i_in_data.stamp_us;
                        n_ex      = r_cfg_x;
                        n_ey      = r_cfg_y;
                        n_heading = r_cfg_h[31 -: ANGLE_BITS];
                        n_vx      = '0;
                        n_vy      = '0;
                        n_half    = 1'b1;
                        n_state   = ST_CINIT;
                    end else begin
                        n_state = ST_DT;
                    end
                end
            end
            ST_DT: begin
                n_dt    = sat32(64'(w_diff));
                n_prev  = r_in.stamp_us;
                n_op    = OP_AX;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_prod = w_prod;
                case (r_op)
                    OP_AX, OP_AY, OP_PX, OP_PY: n_state = ST_DLD;
                    OP_VX2:  n_op = OP_VY2;
                    OP_VY2:  begin n_sq = r_prod[63:0]; n_state = ST_SUM; end
                    OP_SPDC, OP_SPDS: n_state = ST_POS;
                    OP_RATE: n_state = ST_MAG;
                    OP_HI:   n_op = OP_LO;
                    default: begin n_sq = r_prod[63:0]; n_state = ST_HEAD; end
                endcase
            end
            ST_DLD: begin
                n_neg   = r_prod[67];
                n_num   = r_prod[67] ? 64'(-r_prod) : r_prod[63:0];
                n_quo   = '0;
                n_cnt   = '0;
                n_state = ST_DEST;
            end
            ST_DEST: begin
                // division by one million: estimate never exceeds the true quotient
                n_qest  = r_cnt[0] ? 44'(w_prod[64:52]) : w_prod[64:21];
                n_state = ST_DBACK;
            end
            ST_DBACK: begin
                n_back  = w_back;
                n_state = ST_DSUB;
            end
            ST_DSUB: begin
                n_num = r_num - r_back;
                n_quo = r_quo + 45'(r_qest);
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd1) begin
                    n_state = ST_DFIX;
                end else begin
                    n_state = ST_DEST;
                end
            end
            ST_DFIX: begin
                // at most one more million is left after the fine round
                if (r_num >= 64'(US_PER_S)) begin
                    n_quo = r_quo + 45'd1;
                end
                n_state = ST_DACC;
            end
            ST_DACC: begin
                n_state = ST_MUL;
                case (r_op)
                    OP_AX:   begin n_vx = sat32(64'(w_acc)); n_op = OP_AY;   end
                    OP_AY:   begin n_vy = sat32(64'(w_acc)); n_op = OP_VX2;  end
                    OP_PX:   begin n_ex = sat32(64'(w_acc)); n_op = OP_SPDS; end
                    default: begin n_ey = sat32(64'(w_acc)); n_op = OP_RATE; end
                endcase
            end
            ST_SUM: begin
                n_num   = r_sq + r_prod[63:0];
                n_srem  = '0;
                n_root  = '0;
                n_cnt   = '0;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (w_srsh >= w_trial) begin
                    n_srem = w_srsh - w_trial;
                    n_root = {r_root[30:0], 1'b1};
                end else begin
                    n_srem = w_srsh;
                    n_root = {r_root[30:0], 1'b0};
                end
                n_num = {r_num[61:0], 2'b00};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    n_half  = 1'b0;
                    n_state = ST_CINIT;
                end
            end
            ST_CINIT: begin
                n_cx = CORDIC_GAIN;
                n_cy = '0;
                // fold the angle into plus or minus one eighth turn
                if (w_ang[29]) begin
                    n_cz = $signed({4'b0, w_ang[29:0]}) - 34'sd1073741824;
                    n_q  = w_ang[31:30] + 2'd1;
                end else begin
                    n_cz = $signed({4'b0, w_ang[29:0]});
                    n_q  = w_ang[31:30];
                end
                n_cnt   = '0;
                n_state = ST_CORDIC;
            end
            ST_CORDIC: begin
                if (!r_cz[33]) begin
                    n_cx = r_cx - w_dx;
                    n_cy = r_cy + w_dy;
                    n_cz = r_cz - w_atan;
                end else begin
                    n_cx = r_cx + w_dx;
                    n_cy = r_cy - w_dy;
                    n_cz = r_cz + w_atan;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(CORDIC_STEPS - 1)) begin
                    n_state = ST_CDONE;
                end
            end
            ST_CDONE: begin
                n_cos = clamp_q30(w_mc);
                n_sin = clamp_q30(w_ms);
                if (r_half) begin
                    n_state = ST_OUT;
                end else begin
                    n_op    = OP_SPDC;
                    n_state = ST_MUL;
                end
            end
            ST_POS: begin
                n_p     = w_pos[33:0];
                n_op    = (r_op == OP_SPDC) ? OP_PX : OP_PY;
                n_state = ST_MUL;
            end
            ST_MAG: begin
                n_neg   = r_prod[67];
                n_mag   = r_prod[67] ? 55'(-r_prod) : r_prod[54:0];
                n_op    = OP_HI;
                n_state = ST_MUL;
            end
            ST_HEAD: begin
                n_heading = r_neg ? (r_heading - w_inc[ANGLE_BITS-1:0])
                                  : (r_heading + w_inc[ANGLE_BITS-1:0]);
                n_half  = 1'b1;
                n_state = ST_CINIT;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.pos_x     = r_ex;
                    n_out.pos_y     = r_ey;
                    n_out.quat_z    = r_sin;
                    n_out.quat_w    = r_cos;
                    n_out.stamp_out = r_in.stamp_us;
                    n_out_valid     = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_seen      <= 1'b0;
            r_op        <= OP_AX;
            r_half      <= 1'b0;
            r_cnt       <= '0;
            r_prev      <= '0;
            r_vx        <= '0;
            r_vy        <= '0;
            r_ex        <= '0;
            r_ey        <= '0;
            r_heading   <= '0;
            r_cfg_x     <= '0;
            r_cfg_y     <= '0;
            r_cfg_h     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_seen      <= n_seen;
            r_op        <= n_op;
            r_half      <= n_half;
            r_cnt       <= n_cnt;
            r_prev      <= n_prev;
            r_vx        <= n_vx;
            r_vy        <= n_vy;
            r_ex        <= n_ex;
            r_ey        <= n_ey;
            r_heading   <= n_heading;
            r_cfg_x     <= n_cfg_x;
            r_cfg_y     <= n_cfg_y;
            r_cfg_h     <= n_cfg_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_dt   <= n_dt;
        r_prod <= n_prod;
        r_sq   <= n_sq;
        r_num  <= n_num;
        r_quo  <= n_quo;
        r_qest <= n_qest;
        r_back <= n_back;
        r_neg  <= n_neg;
        r_srem <= n_srem;
        r_root <= n_root;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_cz   <= n_cz;
        r_p    <= n_p;
        r_q    <= n_q;
        r_cos  <= n_cos;
        r_sin  <= n_sin;
        r_mag  <= n_mag;
        r_out  <= n_out;
    end

endmodule

[tb/sv/tb.sv]
// tb: self-checking testbench for imu_dead_reckoning with a pose predictor and scoreboard
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imudr_pkg::*;

    localparam longint CYCLE_LIMIT  = 8000000;
    localparam longint Q30          = 1073741824;
    localparam longint US_IN_S      = 1000000;
    localparam longint RAD_TO_ANGLE = 716770142;
    localparam int     DRAIN_CYCLES = 500;
    localparam int     HOLD_CYCLES  = 3000;

    localparam longint ATAN_Q32 [0:29] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    imu_dead_reckoning i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [31:0] pose_x0, pose_y0, pose_h0;
    bit          have_origin;
    logic [47:0] last_stamp;
    longint      vx, vy, px, py;
    logic [31:0] yaw;

    t_out   pose_q[$];
    int     bad_fields;
    longint cyc;
    bit     hold_go;
    logic [47:0] stamp_now;

    initial i_clk = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint sat_s32(input longint v);
        longint r;
        r = v;
        if (v > 64'sd2147483647) r = 64'sd2147483647;
        if (v < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic longint clip_q30(input longint v);
        longint r;
        r = v;
        if (v > Q30) r = Q30;
        if (v < -Q30) r = -Q30;
        return r;
    endfunction

    function automatic logic [31:0] root64(input logic [63:0] v);
        logic [63:0] r, b, rem;
        r = 0;
        rem = v;
        b = 64'h1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    // cordic rotation of a binary angle, cos and sin in q2.30
    task automatic rotate(input logic [31:0] a, output longint c, output longint s);
        logic [1:0] q;
        longint z, x, y, dx, dy, cx, sy;
        q = a[31:30];
        z = longint'(a[29:0]);
        x = 652032874;
        y = 0;
        if (z >= (64'sd1 << 29)) begin
            z = z - (64'sd1 << 30);
            q = q + 2'd1;
        end
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_Q32[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_Q32[i];
            end
        end
        case (q)
            2'd0: begin cx = x;  sy = y;  end
            2'd1: begin cx = -y; sy = x;  end
            2'd2: begin cx = -x; sy = -y; end
            default: begin cx = y; sy = -x; end
        endcase
        c = clip_q30(cx);
        s = clip_q30(sy);
    endtask

    task automatic advance_pose(input t_in d, output t_out r);
        longint ax, ay, rate, dt, c, s, m, mag, inc;
        logic [31:0] spd;
        logic [63:0] sq;
        ax = longint'($signed(d.accel_x));
        ay = longint'($signed(d.accel_y));
        rate = longint'($signed(d.yaw_rate));
        if (!have_origin) begin
            have_origin = 1'b1;
            px = longint'($signed(pose_x0));
            py = longint'($signed(pose_y0));
            yaw = pose_h0;
            vx = 0;
            vy = 0;
        end else begin
            dt = sat_s32(longint'({16'd0, d.stamp_us}) - longint'({16'd0, last_stamp}));
            vx = sat_s32(vx + (ax * dt) / US_IN_S);
            vy = sat_s32(vy + (ay * dt) / US_IN_S);
            sq = 64'(vx * vx) + 64'(vy * vy);
            spd = root64(sq);
            rotate(yaw, c, s);
            px = sat_s32(px + (((longint'({32'd0, spd}) * c) / Q30) * dt) / US_IN_S);
            py = sat_s32(py + (((longint'({32'd0, spd}) * s) / Q30) * dt) / US_IN_S);
            m = rate * dt;
            mag = (m < 0) ? -m : m;
            inc = ((mag >>> 24) * RAD_TO_ANGLE + (((mag & 64'hFFFFFF) * RAD_TO_ANGLE) >>> 24))
                  >>> 12;
            if (m < 0) yaw = yaw - inc[31:0];
            else yaw = yaw + inc[31:0];
        end
        last_stamp = d.stamp_us;
        rotate(yaw >> 1, c, s);
        r.pos_x = px[31:0];
        r.pos_y = py[31:0];
        r.quat_z = s[31:0];
        r.quat_w = c[31:0];
        r.stamp_out = d.stamp_us;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 6);
        return $urandom_range(20, 400);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_INIT_X:       pose_x0 = v;
            CFG_INIT_Y:       pose_y0 = v;
            CFG_INIT_HEADING: pose_h0 = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // one sample transfer; typed pose overrides the predicted position when given
    task automatic send_sample(input t_in d, input bit typed, input logic [31:0] tx,
                               input logic [31:0] ty);
        t_out e;
        int g;
        i_in_valid <= 1'b1;
        i_in_data <= d;
        do @(posedge i_clk); while (o_in_stall);
        advance_pose(d, e);
        if (typed) begin
            e.pos_x = tx;
            e.pos_y = ty;
        end
        pose_q.push_back(e);
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in rand_sample();
        t_in d;
        int r;
        longint step;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            d.accel_x = 24'($signed($urandom_range(0, 2 * 655360)) - 655360);
            d.accel_y = 24'($signed($urandom_range(0, 2 * 655360)) - 655360);
            d.yaw_rate = 24'($signed($urandom_range(0, 2 * 262144)) - 262144);
        end else begin
            d.accel_x = 24'($urandom);
            d.accel_y = 24'($urandom);
            d.yaw_rate = 24'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 80) step = $urandom_range(100, 20000);
        else if (r < 86) step = 0;
        else if (r < 93) step = -longint'($urandom_range(1, 50000));
        else step = $urandom_range(20000, 5000000);
        if ($urandom_range(0, 99) < 3) d.stamp_us = {16'($urandom), $urandom};
        else d.stamp_us = stamp_now + 48'(step);
        stamp_now = d.stamp_us;
        return d;
    endfunction

    typedef struct {
        t_in         d;
        bit          typed;
        logic [31:0] tx;
        logic [31:0] ty;
    } t_row;

    // directed rows: the first two have a pose that is obvious from the registers
    function automatic t_row mk(input logic [23:0] ax, input logic [23:0] ay,
                                input logic [23:0] rt, input logic [47:0] st,
                                input bit typed, input logic [31:0] tx,
                                input logic [31:0] ty);
        t_row r;
        r.d.accel_x = ax;
        r.d.accel_y = ay;
        r.d.yaw_rate = rt;
        r.d.stamp_us = st;
        r.typed = typed;
        r.tx = tx;
        r.ty = ty;
        return r;
    endfunction

    // scoreboard
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pose_q.size() == 0) begin
                bad_fields++;
                if (bad_fields <= 10) $display("unexpected transfer: %p", o_out_data);
            end else begin
                e = pose_q.pop_front();
                if (o_out_data !== e) begin
                    bad_fields++;
                    if (bad_fields <= 10)
                        $display("pose mismatch: exp x=%0d y=%0d z=%0d w=%0d t=%0d  got x=%0d y=%0d z=%0d w=%0d t=%0d",
                                 e.pos_x, e.pos_y, e.quat_z, e.quat_w, e.stamp_out,
                                 o_out_data.pos_x, o_out_data.pos_y, o_out_data.quat_z,
                                 o_out_data.quat_w, o_out_data.stamp_out);
                end
            end
        end
    end

    // receiver stall, with one long hold-off
    int  stall_left;
    bit  stall_on;
    int  hold_left;
    bit  hold_used;
    always @(posedge i_clk) begin
        int r;
        if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= stall_on;
        end else begin
            r = $urandom_range(0, 99);
            stall_on <= (r < 35);
            stall_left <= (r < 95) ? $urandom_range(0, 6) : $urandom_range(20, 400);
            i_out_stall <= (r < 35);
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_INIT_X;
        i_cfg_data = '0;
        pose_x0 = 0; pose_y0 = 0; pose_h0 = 0;
        have_origin = 1'b0;
        last_stamp = 0;
        vx = 0; vy = 0; px = 0; py = 0; yaw = 0;
        bad_fields = 0;
        cyc = 0;
        hold_go = 1'b0;
        hold_used = 1'b0;
        hold_left = 0;
        stall_left = 0;
        stall_on = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_INIT_X, 32'h7FFFFFFF);
        write_reg(CFG_INIT_Y, 32'h80000000);
        write_reg(CFG_INIT_HEADING, 32'hFFFFFFFF);
        write_reg(2'd3, 32'hDEADBEEF);

        rows.push_back(mk(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 48'd1000, 1,
                          32'h7FFFFFFF, 32'h80000000));
        // zero dt keeps the pose
        rows.push_back(mk(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 48'd1000, 1,
                          32'h7FFFFFFF, 32'h80000000));
        rows.push_back(mk(24'h010000, 24'hFF0000, 24'h010000, 48'd11000, 0, 0, 0));
        rows.push_back(mk(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 48'hFFFFFFFFFFFF, 0, 0, 0));
        // time going backward, dt saturated negative
        rows.push_back(mk(24'h800000, 24'h800000, 24'h800000, 48'd0, 0, 0, 0));
        rows.push_back(mk(24'h800000, 24'h7FFFFF, 24'h000000, 48'd5000000, 0, 0, 0));
        rows.push_back(mk(24'h000000, 24'h000000, 24'h7FFFFF, 48'd9000000, 0, 0, 0));
        rows.push_back(mk(24'h000001, 24'hFFFFFF, 24'hFFFFFF, 48'd8999000, 0, 0, 0));
        rows.push_back(mk(24'hFFFFFF, 24'h000001, 24'h000001, 48'd9001000, 0, 0, 0));
        rows.push_back(mk(24'h7FFFFF, 24'h000000, 24'h400000, 48'd9003000, 0, 0, 0));
        rows.push_back(mk(24'h000000, 24'h800000, 24'hC00000, 48'd9013000, 0, 0, 0));
        rows.push_back(mk(24'h555555, 24'hAAAAAA, 24'h555555, 48'hAAAAAAAAAAAA, 0, 0, 0));
        rows.push_back(mk(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 48'h555555555555, 0, 0, 0));
        rows.push_back(mk(24'h000100, 24'h000100, 24'h000010, 48'h555555556000, 0, 0, 0));
        foreach (rows[i]) send_sample(rows[i].d, rows[i].typed, rows[i].tx, rows[i].ty);
        stamp_now = 48'h555555556000;
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_INIT_X, 32'h0);
                    write_reg(CFG_INIT_Y, 32'h0);
                    write_reg(CFG_INIT_HEADING, 32'h0);
                end
                1: begin
                    write_reg(CFG_INIT_X, 32'h80000000);
                    write_reg(CFG_INIT_Y, 32'h7FFFFFFF);
                    write_reg(CFG_INIT_HEADING, 32'h80000000);
                    hold_go = 1'b1;
                end
                2: begin
                    write_reg(CFG_INIT_X, $urandom);
                    write_reg(CFG_INIT_Y, $urandom);
                    write_reg(CFG_INIT_HEADING, $urandom);
                    write_reg(2'd3, $urandom);
                end
                default: ;
            endcase
            repeat (345) send_sample(rand_sample(), 0, 0, 0);
            wait_drained();
        end

        if (bad_fields == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
